[src/mpq_pkg.sv]
// shared types, sizes and codes of the multilevel priority fifo
`timescale 1ns / 1ps

package mpq_pkg;

    // storage sizes
    localparam int NUM_LEVELS    = 16;
    localparam int RING_CAPACITY = 16;
    localparam int STORE_DEPTH   = NUM_LEVELS * RING_CAPACITY;

    // derived widths
    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int NLEV_W = $clog2(NUM_LEVELS + 1);
    localparam int SLOT_W = $clog2(RING_CAPACITY);
    localparam int OCC_W  = $clog2(RING_CAPACITY + 1);
    localparam int ADDR_W = LVL_W + SLOT_W;

    // port field widths
    localparam int WORD_W   = 32;
    localparam int FLEVEL_W = 4;
    localparam int STAT_W   = 2;
    localparam int CFG_W    = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // register reset values
    localparam logic [CFG_W-1:0] LEVELS_RST = CFG_W'(16);
    localparam logic [CFG_W-1:0] DEPTH_RST  = CFG_W'(16);

    // register indexes
    localparam logic REG_LEVELS = 1'b0;
    localparam logic REG_DEPTH  = 1'b1;

    // commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_LEVEL = 2'd3;

    // clamped configuration seen by the ring control
    typedef struct packed {
        logic [NLEV_W-1:0] nlev;
        logic [OCC_W-1:0]  depth;
        logic              flush;
    } t_cfg;

    // outcome of one command and the store access it needs
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LVL_W-1:0]  served_level;
        logic              pop_ok;
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
    } t_ring_result;

endpackage

[src/multilevel_priority_fifo_top.sv]
// top level of the multilevel priority fifo
`timescale 1ns / 1ps

// Priority queue of 16 levels, each a circular fifo of up to 16 words held in
// one 256-word single-port store. Insert appends to the given level; remove
// pops the oldest word of the highest non-empty level in use. Commands are
// handled one at a time: a command is taken, and the store accessed, at the
// clock edge of its transfer; the read word is then registered in the load
// state, and the result is offered in the hold state until it is taken. The
// next command is taken only after the result transfer, so an output stall
// holds the intake. Writing ring_depth flushes every ring at the clock edge
// of the write itself; no clearing pass of the store is needed after reset.

module multilevel_priority_fifo_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic signed [mpq_pkg::WORD_W-1:0]  i_data_word,
    input  logic [mpq_pkg::FLEVEL_W-1:0]       i_priority_level,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [mpq_pkg::STAT_W-1:0]         o_status,
    output logic signed [mpq_pkg::WORD_W-1:0]  o_removed_word,
    output logic [mpq_pkg::FLEVEL_W-1:0]       o_served_level,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mpq_pkg::PADDR_W-1:0]        paddr,
    input  logic [mpq_pkg::PDATA_W-1:0]        pwdata,
    output logic [mpq_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [mpq_pkg::STAT_W-1:0]  r_status;
    logic [mpq_pkg::LVL_W-1:0]   r_served;
    logic                        r_pop_ok;
    logic [mpq_pkg::WORD_W-1:0]  r_word;

    mpq_pkg::t_cfg               w_cfg;
    mpq_pkg::t_ring_result       w_res;
    logic                        w_fire;
    logic [mpq_pkg::WORD_W-1:0]  w_rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_fire     = i_in_valid && o_in_ready;

    mpq_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mpq_ring_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_fire           (w_fire),
        .i_command        (i_command),
        .i_priority_level (i_priority_level),
        .o_res            (w_res)
    );

    mpq_word_ram #(
        .DEPTH  (mpq_pkg::STORE_DEPTH),
        .ADDR_W (mpq_pkg::ADDR_W),
        .DATA_W (mpq_pkg::WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_res.we),
        .i_re    (w_res.re),
        .i_addr  (w_res.addr),
        .i_wdata (i_data_word),
        .o_rdata (w_rdata)
    );

    // command sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_fire) n_state = S_LOAD;
            S_LOAD:  n_state = S_HOLD;
            S_HOLD:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result capture at the command transfer
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= w_res.status;
            r_served <= w_res.served_level;
            r_pop_ok <= w_res.pop_ok;
        end
    end

    // popped word from the store read
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_word <= r_pop_ok ? w_rdata : '0;
        end
    end

    assign o_out_valid    = (r_state == S_HOLD);
    assign o_status       = r_status;
    assign o_removed_word = r_word;
    assign o_served_level = mpq_pkg::FLEVEL_W'(r_served);

endmodule

[src/mpq_word_ram.sv]
// single-port word store with registered read data
`timescale 1ns / 1ps

module mpq_word_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/mpq_cfg_regs.sv]
// apb configuration registers: level count and ring depth
`timescale 1ns / 1ps

module mpq_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mpq_pkg::PADDR_W-1:0]  paddr,
    input  logic [mpq_pkg::PDATA_W-1:0]  pwdata,
    output logic [mpq_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output mpq_pkg::t_cfg                o_cfg
);

    logic [mpq_pkg::CFG_W-1:0] r_levels;
    logic [mpq_pkg::CFG_W-1:0] r_depth;
    logic                      w_wr;
    logic                      w_sel;

    assign pready = 1'b1;
    assign w_sel  = paddr[2];
    assign w_wr   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= mpq_pkg::LEVELS_RST;
            r_depth  <= mpq_pkg::DEPTH_RST;
        end else begin
            if (w_wr) begin
                case (w_sel)
                    mpq_pkg::REG_LEVELS: r_levels <= pwdata[mpq_pkg::CFG_W-1:0];
                    mpq_pkg::REG_DEPTH:  r_depth  <= pwdata[mpq_pkg::CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // read back raw values
    always_comb begin
        prdata = '0;
        case (w_sel)
            mpq_pkg::REG_LEVELS: prdata[mpq_pkg::CFG_W-1:0] = r_levels;
            mpq_pkg::REG_DEPTH:  prdata[mpq_pkg::CFG_W-1:0] = r_depth;
            default:             prdata = '0;
        endcase
    end

    // clamp to the supported ranges; a depth write flushes every ring at the same edge
    always_comb begin
        if (r_levels == '0) begin
            o_cfg.nlev = mpq_pkg::NLEV_W'(1);
        end else if (32'(r_levels) > mpq_pkg::NUM_LEVELS) begin
            o_cfg.nlev = mpq_pkg::NLEV_W'(mpq_pkg::NUM_LEVELS);
        end else begin
            o_cfg.nlev = mpq_pkg::NLEV_W'(r_levels);
        end
        if (r_depth == '0) begin
            o_cfg.depth = mpq_pkg::OCC_W'(1);
        end else if (32'(r_depth) > mpq_pkg::RING_CAPACITY) begin
            o_cfg.depth = mpq_pkg::OCC_W'(mpq_pkg::RING_CAPACITY);
        end else begin
            o_cfg.depth = mpq_pkg::OCC_W'(r_depth);
        end
        o_cfg.flush = w_wr && (w_sel == mpq_pkg::REG_DEPTH);
    end

endmodule

[src/mpq_ring_ctrl.sv]
// per-level head and occupancy, level search and store address generation
`timescale 1ns / 1ps

module mpq_ring_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mpq_pkg::t_cfg                 i_cfg,
    input  logic                          i_fire,
    input  logic                          i_command,
    input  logic [mpq_pkg::FLEVEL_W-1:0]  i_priority_level,
    output mpq_pkg::t_ring_result         o_res
);

    logic [mpq_pkg::SLOT_W-1:0] r_head [mpq_pkg::NUM_LEVELS];
    logic [mpq_pkg::OCC_W-1:0]  r_occ  [mpq_pkg::NUM_LEVELS];

    logic [mpq_pkg::LVL_W-1:0]  w_ins_lvl;
    logic [mpq_pkg::LVL_W-1:0]  w_pop_lvl;
    logic [mpq_pkg::LVL_W-1:0]  w_lvl;
    logic                       w_found;
    logic                       w_bad;
    logic                       w_full;
    logic [mpq_pkg::SLOT_W-1:0] w_head;
    logic [mpq_pkg::OCC_W-1:0]  w_occ;
    logic [mpq_pkg::OCC_W:0]    w_sum;
    logic [mpq_pkg::SLOT_W-1:0] w_tail;
    logic [mpq_pkg::OCC_W-1:0]  w_head_inc;
    logic [mpq_pkg::SLOT_W-1:0] w_head_nxt;
    logic                       w_ins_ok;
    logic                       w_pop_ok;

    assign w_ins_lvl = mpq_pkg::LVL_W'(i_priority_level);
    assign w_bad     = 32'(i_priority_level) >= 32'(i_cfg.nlev);

    // highest non-empty level in use
    always_comb begin
        w_found   = 1'b0;
        w_pop_lvl = '0;
        for (int i = 0; i < mpq_pkg::NUM_LEVELS; i++) begin
            if (i < 32'(i_cfg.nlev) && r_occ[i] != '0) begin
                w_found   = 1'b1;
                w_pop_lvl = mpq_pkg::LVL_W'(i);
            end
        end
    end

    // one level is touched per command
    assign w_lvl  = (i_command == mpq_pkg::CMD_REMOVE) ? w_pop_lvl : w_ins_lvl;
    assign w_head = r_head[w_lvl];
    assign w_occ  = r_occ[w_lvl];
    assign w_full = w_occ >= i_cfg.depth;

    // tail slot, head below depth so one subtract wraps it
    always_comb begin
        w_sum = (mpq_pkg::OCC_W+1)'(w_head) + (mpq_pkg::OCC_W+1)'(w_occ);
        if (w_sum >= (mpq_pkg::OCC_W+1)'(i_cfg.depth)) begin
            w_sum = w_sum - (mpq_pkg::OCC_W+1)'(i_cfg.depth);
        end
        w_tail = mpq_pkg::SLOT_W'(w_sum);
    end

    // head advance with wrap at depth
    always_comb begin
        w_head_inc = mpq_pkg::OCC_W'(w_head) + mpq_pkg::OCC_W'(1);
        w_head_nxt = (w_head_inc == i_cfg.depth) ? '0 : mpq_pkg::SLOT_W'(w_head_inc);
    end

    assign w_ins_ok = (i_command == mpq_pkg::CMD_INSERT) && !w_bad && !w_full;
    assign w_pop_ok = (i_command == mpq_pkg::CMD_REMOVE) && w_found;

    // result status and store access
    always_comb begin
        if (i_command == mpq_pkg::CMD_INSERT) begin
            if (w_bad) begin
                o_res.status = mpq_pkg::ST_BAD_LEVEL;
            end else if (w_full) begin
                o_res.status = mpq_pkg::ST_FULL;
            end else begin
                o_res.status = mpq_pkg::ST_OK;
            end
        end else begin
            o_res.status = w_found ? mpq_pkg::ST_OK : mpq_pkg::ST_EMPTY;
        end
        o_res.served_level = w_pop_ok ? w_pop_lvl : '0;
        o_res.pop_ok       = w_pop_ok;
        o_res.we           = i_fire && w_ins_ok;
        o_res.re           = i_fire && w_pop_ok;
        o_res.addr         = w_pop_ok ? {w_lvl, w_head} : {w_lvl, w_tail};
    end

    // pointer and count update, flush on a depth write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.flush) begin
            for (int i = 0; i < mpq_pkg::NUM_LEVELS; i++) begin
                r_head[i] <= '0;
                r_occ[i]  <= '0;
            end
        end else if (i_fire) begin
            if (w_ins_ok) begin
                r_occ[w_lvl] <= w_occ + mpq_pkg::OCC_W'(1);
            end else if (w_pop_ok) begin
                r_head[w_lvl] <= w_head_nxt;
                r_occ[w_lvl]  <= w_occ - mpq_pkg::OCC_W'(1);
            end
        end
    end

endmodule

[src/mpq_checker.sv]
// port-level checks of the multilevel priority fifo and their binding
`timescale 1ns / 1ps

module mpq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [mpq_pkg::STAT_W-1:0]         o_status,
    input logic signed [mpq_pkg::WORD_W-1:0]  o_removed_word,
    input logic [mpq_pkg::FLEVEL_W-1:0]       o_served_level
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    // one command in flight: no intake while a result is offered
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("command taken while result pending");

    // result follows the store read: not offered in the load state, offered in the hold state after it
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_out_valid ##1 o_out_valid)
        else $error("result not offered two cycles after command");

    // failed commands carry zero word and level
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != mpq_pkg::ST_OK |->
            o_removed_word == '0 && o_served_level == '0)
        else $error("failed command returned data");

endmodule

bind multilevel_priority_fifo_top mpq_checker u_mpq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_removed_word (o_removed_word),
    .o_served_level (o_served_level)
);
